// File: rtl/core/cv_frame_deframer_macros.svh
// ---------------------------------------------------------------------------
// cv_frame_deframer assertion macros
// concurrent assertion forms used by the cvfd_queue module
// ---------------------------------------------------------------------------
`ifndef CV_FRAME_DEFRAMER_MACROS_SVH
`define CV_FRAME_DEFRAMER_MACROS_SVH

// checked outside reset
`define CVFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define CVFD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/cvfd_pkg.sv
// ---------------------------------------------------------------------------
// cvfd_pkg
// constants and types shared by the channel frame deframer
// ---------------------------------------------------------------------------
package cvfd_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int FRAME_LEN    = 2 * NUM_CHANNELS + 2;
  localparam int POS_W        = $clog2(FRAME_LEN + 1);
  localparam int MAX_RESULTS  = 8;
  localparam int SHOWN        = (NUM_CHANNELS < MAX_RESULTS) ? NUM_CHANNELS : MAX_RESULTS;
  localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int BYTE_W       = 8;
  localparam int RAW_W        = 16;
  localparam int CV_W         = 11;
  localparam int LED_SHIFT    = 11;
  localparam int OUT_CH_W     = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 11;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_CODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDENTIFY_CODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_MAX       = 2'd2;

  localparam logic [CV_W-1:0] PWM_MAX_RESET = 11'd2047;

  typedef enum logic {
    KIND_CHANNEL  = 1'b0,
    KIND_IDENTIFY = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t                                kind;
    logic [NUM_CHANNELS-1:0][RAW_W-1:0]   raw;
  } frame_cmd_t;

  typedef struct packed {
    logic       valid;
    frame_cmd_t cmd;
  } queue_head_t;

endpackage

// File: rtl/core/cv_frame_deframer.sv
// Path: queue entry, then sequencer hold register, then registered result outputs.
// Throughput: one byte per cycle while the 2-entry command queue has room;
//   the sequencer takes commands one at a time, 8 results per frame (1 for identify).
// Reset: synchronous, clears parser counters, queue and sequencer and loads
//   register defaults (codes 0, pwm_max 2047); staged channel values are not cleared.
// ---------------------------------------------------------------------------
// cv_frame_deframer
// channel frame and identify command decoder with clamped and squared levels
// ---------------------------------------------------------------------------
module cv_frame_deframer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cvfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cvfd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [cvfd_pkg::BYTE_W-1:0]     data_byte,
  input  logic                            end_of_transfer,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            result_kind,
  output logic [cvfd_pkg::OUT_CH_W-1:0]   channel,
  output logic [cvfd_pkg::CV_W-1:0]       cv_level,
  output logic [cvfd_pkg::CV_W-1:0]       led_level,
  output logic                            last_of_run
);
  import cvfd_pkg::*;

  logic [BYTE_W-1:0] sync_code;
  logic [BYTE_W-1:0] identify_code;
  logic [CV_W-1:0]   pwm_max;
  logic              queue_full;
  logic              push;
  frame_cmd_t        push_cmd;
  logic              pop;
  queue_head_t       head;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_code     <= '0;
      identify_code <= '0;
      pwm_max       <= PWM_MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_CODE:     sync_code     <= cfg_data[BYTE_W-1:0];
        REG_IDENTIFY_CODE: identify_code <= cfg_data[BYTE_W-1:0];
        REG_PWM_MAX:       pwm_max       <= cfg_data[CV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cvfd_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .end_of_transfer (end_of_transfer),
    .sync_code       (sync_code),
    .identify_code   (identify_code),
    .queue_full      (queue_full),
    .push            (push),
    .push_cmd        (push_cmd)
  );

  cvfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (pop),
    .head     (head)
  );

  cvfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .pwm_max     (pwm_max),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .channel     (channel),
    .cv_level    (cv_level),
    .led_level   (led_level),
    .last_of_run (last_of_run)
  );

endmodule

// File: rtl/core/cvfd_front.sv
// ---------------------------------------------------------------------------
// cvfd_front
// byte parser: tracks the transaction, stages channel values, classifies ends
// ---------------------------------------------------------------------------
module cvfd_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cvfd_pkg::BYTE_W-1:0] data_byte,
  input  logic                        end_of_transfer,
  input  logic [cvfd_pkg::BYTE_W-1:0] sync_code,
  input  logic [cvfd_pkg::BYTE_W-1:0] identify_code,
  input  logic                        queue_full,
  output logic                        push,
  output cvfd_pkg::frame_cmd_t        push_cmd
);
  import cvfd_pkg::*;

  logic [POS_W-1:0]                   byte_count;
  logic [BYTE_W-1:0]                  running_xor;
  logic [BYTE_W-1:0]                  first_byte;
  logic [BYTE_W-1:0]                  low_half;
  logic [NUM_CHANNELS-1:0][RAW_W-1:0] staged;
  logic                               accept;
  logic                               frame_ok;
  logic                               ident_ok;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  assign frame_ok = (byte_count == POS_W'(FRAME_LEN - 1)) && (first_byte == sync_code) &&
                    (running_xor == data_byte);
  assign ident_ok = (byte_count == '0) && (data_byte == identify_code);

  assign push          = accept && end_of_transfer && (frame_ok || ident_ok);
  assign push_cmd.kind = ident_ok ? KIND_IDENTIFY : KIND_CHANNEL;
  assign push_cmd.raw  = staged;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      running_xor <= '0;
      first_byte  <= '0;
    end else if (accept) begin
      if (byte_count == '0) begin
        first_byte <= data_byte;
      end
      if (end_of_transfer) begin
        byte_count  <= '0;
        running_xor <= '0;
      end else begin
        running_xor <= running_xor ^ data_byte;
        if (byte_count < POS_W'(FRAME_LEN)) begin
          byte_count <= byte_count + POS_W'(1);
        end
      end
    end
  end

  // low byte on odd positions 1 to 15, full channel value on even positions 2 to 16
  always_ff @(posedge clk) begin
    if (accept) begin
      if (byte_count[0] && byte_count <= POS_W'(2 * NUM_CHANNELS)) begin
        low_half <= data_byte;
      end
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (byte_count == POS_W'(2 * i + 2)) begin
          staged[i] <= {data_byte, low_half};
        end
      end
    end
  end

endmodule

// File: rtl/core/cvfd_queue.sv
// ---------------------------------------------------------------------------
// cvfd_queue
// short command queue between the parser and the result sequencer
// ---------------------------------------------------------------------------
`include "cv_frame_deframer_macros.svh"

module cvfd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  cvfd_pkg::frame_cmd_t  push_cmd,
  output logic                  full,
  input  logic                  pop,
  output cvfd_pkg::queue_head_t head
);
  import cvfd_pkg::*;

  frame_cmd_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  `CVFD_ASSERT(a_no_push_when_full, push |-> !full, "transaction pushed into full queue")
  `CVFD_ASSERT(a_count_up, (push && !pop && !full) |=> count == $past(count) + QCNT_W'(1), "queue count lost a push")
  `CVFD_ASSERT(a_count_down, (pop && head.valid && !push) |=> count == $past(count) - QCNT_W'(1), "queue count lost a pop")
  `CVFD_ASSERT_ALWAYS(a_reset_empty, rst |=> count == '0, "queue not empty after reset")

endmodule

// File: rtl/core/cvfd_back.sv
// ---------------------------------------------------------------------------
// cvfd_back
// result sequencer: clamps each channel, emits one result per unstalled cycle
// ---------------------------------------------------------------------------
module cvfd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  cvfd_pkg::queue_head_t         head,
  output logic                          pop,
  input  logic [cvfd_pkg::CV_W-1:0]     pwm_max,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          result_kind,
  output logic [cvfd_pkg::OUT_CH_W-1:0] channel,
  output logic [cvfd_pkg::CV_W-1:0]     cv_level,
  output logic [cvfd_pkg::CV_W-1:0]     led_level,
  output logic                          last_of_run
);
  import cvfd_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t                             state;
  frame_cmd_t                         hold;
  logic [CH_W-1:0]                    idx;
  logic                               slot_free;
  logic [RAW_W-1:0]                   raw_sel;
  logic [CV_W-1:0]                    cv_next;
  logic [2*CV_W-1:0]                  square;
  logic                               last_next;
  logic [CH_W+OUT_CH_W-1:0]           idx_wide;

  assign slot_free = !out_valid || out_ready;
  assign pop       = (state == ST_IDLE) && head.valid;
  assign raw_sel   = hold.raw[idx];
  assign cv_next   = (raw_sel > RAW_W'(pwm_max)) ? pwm_max : raw_sel[CV_W-1:0];
  assign square    = (2*CV_W)'(cv_next) * (2*CV_W)'(cv_next);
  assign last_next = (idx == CH_W'(SHOWN - 1));
  assign idx_wide  = (CH_W+OUT_CH_W)'(idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (out_ready) begin
            out_valid <= 1'b0;
          end
          if (head.valid) begin
            hold  <= head.cmd;
            idx   <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            if (hold.kind == KIND_IDENTIFY) begin
              result_kind <= KIND_IDENTIFY;
              channel     <= '0;
              cv_level    <= '0;
              led_level   <= '0;
              last_of_run <= 1'b1;
              state       <= ST_IDLE;
            end else begin
              result_kind <= KIND_CHANNEL;
              channel     <= idx_wide[OUT_CH_W-1:0];
              cv_level    <= cv_next;
              led_level   <= square[LED_SHIFT +: CV_W];
              last_of_run <= last_next;
              if (last_next) begin
                state <= ST_IDLE;
              end else begin
                idx <= idx + CH_W'(1);
              end
            end
          end
        end
        default: begin
          if (out_ready) begin
            out_valid <= 1'b0;
          end
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
